// ===== rtl/larp_pkg.sv =====
// Shared types and constants for the looping audio read planner.
// Has no dependencies; the divider and the top level import it.
`timescale 1ns / 1ps
package larp_pkg;
    // Widths of the shared divider operands.
    localparam int DIV_DW = 67;
    localparam int DIV_VW = 52;
    localparam int DIV_CW = 7;

    // Microseconds per second.
    localparam logic [19:0] US_PER_SEC = 20'd1000000;

    // Reciprocal of one million scaled by 2^US_QSH, rounded down.
    localparam int          US_QSH   = 44;
    localparam logic [24:0] US_RECIP = 25'd17592186;

    // The scaled time is divided by one million in 12-bit digits, top digit first.
    localparam logic [2:0] US_TOP_DIGIT = 3'd5;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_AUDIO  = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_RATE  = 3'd0;
    localparam logic [2:0] REG_CHAN  = 3'd1;
    localparam logic [2:0] REG_BPS   = 3'd2;
    localparam logic [2:0] REG_WAVE  = 3'd3;
    localparam logic [2:0] REG_BASE  = 3'd4;
    localparam logic [2:0] REG_SLEN  = 3'd5;
endpackage

// ===== rtl/larp_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on larp_pkg for the operand widths.
`timescale 1ns / 1ps
module larp_div import larp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_DW-1:0] i_dividend,
    input  logic [DIV_VW-1:0] i_divisor,
    input  logic [DIV_CW-1:0] i_nbits,
    output logic              o_done,
    output logic [DIV_DW-1:0] o_quot,
    output logic [DIV_VW-1:0] o_rem
);
    logic [DIV_DW-1:0] r_dvd;
    logic [DIV_VW-1:0] r_dvs;
    logic [DIV_DW-1:0] r_q;
    logic [DIV_VW-1:0] r_r;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_done;

    logic [DIV_CW-1:0] idx;
    logic [DIV_VW:0]   trial;
    logic              fits;

    // Shift in the next dividend bit and try the subtraction.
    always_comb begin
        idx   = r_cnt - DIV_CW'(1);
        trial = {r_r, r_dvd[idx]};
        fits  = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd <= i_dividend;
                r_dvs <= i_divisor;
                r_q   <= '0;
                r_r   <= '0;
                r_cnt <= i_nbits;
            end else if (r_cnt != '0) begin
                r_q   <= {r_q[DIV_DW-2:0], fits};
                r_r   <= fits ? DIV_VW'(trial - {1'b0, r_dvs}) : trial[DIV_VW-1:0];
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

// ===== rtl/looping_audio_read_planner.sv =====
// Looping audio read planner: one request in, up to MAX_SEGMENTS read descriptors out.
// The first result waits on the bit-serial divider for the configured divisors; each further
// piece is formed in S_SEG only after the previous one has been taken in S_OUT.
// One request at a time; s_axis_tready is low until the last result has been taken.
// Synchronous active-low reset restores the register defaults and idles the sequencer.
// Depends on larp_pkg and larp_div.
`timescale 1ns / 1ps
module looping_audio_read_planner import larp_pkg::*; #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // APB configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    // Request stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [71:0]   s_axis_tdata,   // [39:0] start_us, [71:40] span_us
    // Descriptor stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata,   // [1:0] status, [34:2] read_address,
                                          // [66:35] read_count, [98:67] total_bytes, zero pad
    output logic          m_axis_tlast
);
    localparam int SEG_W = $clog2(MAX_SEGMENTS);

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_MUL_LO, S_MUL_HI, S_US_EST, S_US_FIX, S_DIV_FR,
        S_SIZE, S_WRAP, S_SEG, S_OUT
    } t_state;

    // Configuration registers.
    logic [18:0] r_rate;
    logic [3:0]  r_chan;
    logic [2:0]  r_bps;
    logic [31:0] r_wave;
    logic [31:0] r_base;
    logic [51:0] r_slen;

    logic [2:0] wr_idx;
    assign wr_idx = paddr[5:3];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= 19'd48000;
            r_chan <= 4'd2;
            r_bps  <= 3'd2;
            r_wave <= '0;
            r_base <= '0;
            r_slen <= '0;
        end else if (psel && penable && pwrite) begin
            case (wr_idx)
                REG_RATE: r_rate <= pwdata[18:0];
                REG_CHAN: r_chan <= pwdata[3:0];
                REG_BPS:  r_bps  <= pwdata[2:0];
                REG_WAVE: r_wave <= pwdata[31:0];
                REG_BASE: r_base <= pwdata[31:0];
                REG_SLEN: r_slen <= pwdata[51:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (wr_idx)
            REG_RATE: prdata = 64'(r_rate);
            REG_CHAN: prdata = 64'(r_chan);
            REG_BPS:  prdata = 64'(r_bps);
            REG_WAVE: prdata = 64'(r_wave);
            REG_BASE: prdata = 64'(r_base);
            REG_SLEN: prdata = 64'(r_slen);
            default:  prdata = '0;
        endcase
    end

    // Frame size and byte rate are small products taken at request start.
    logic [6:0]  frame_w;
    logic [25:0] k_w;
    assign frame_w = {4'd0, r_bps} * {3'd0, r_chan};
    assign k_w     = {19'd0, frame_w} * {7'd0, r_rate};

    // Shared divider.
    logic              r_dgo;
    logic [DIV_DW-1:0] r_dnd;
    logic [DIV_VW-1:0] r_dvs;
    logic [DIV_CW-1:0] r_dnb;
    logic              div_done;
    logic [DIV_DW-1:0] div_q;
    logic [DIV_VW-1:0] div_r;

    larp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dgo),
        .i_dividend (r_dnd),
        .i_divisor  (r_dvs),
        .i_nbits    (r_dnb),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    t_state            r_state;
    logic [39:0]       r_from;
    logic [31:0]       r_span;
    logic [6:0]        r_frame;
    logic [25:0]       r_k;
    logic [40:0]       r_t;
    logic [DIV_DW-1:0] r_prod;
    logic [47:0]       r_sc;
    logic              r_phase;
    logic [47:0]       r_start;
    logic [47:0]       r_end;
    logic [31:0]       r_size;
    logic [31:0]       r_rem;
    logic [32:0]       r_pos;
    logic [SEG_W-1:0]  r_n;
    logic              r_ov;
    t_status           r_ost;
    logic [32:0]       r_oaddr;
    logic [31:0]       r_ocnt;
    logic [31:0]       r_otot;
    logic              r_olast;
    logic [71:0]       r_xs;
    logic [19:0]       r_urem;
    logic [31:0]       r_uc;
    logic [11:0]       r_uqe;
    logic [47:0]       r_uq;
    logic [2:0]        r_dig;

    // Second partial product of the time scaling.
    logic [DIV_DW-1:0] prod_n;
    assign prod_n = r_prod + (DIV_DW'({27'd0, r_t[40:21]} * {21'd0, r_k}) << 21);

    // Division by one million, one 12-bit digit at a time in S_US_EST and S_US_FIX: a reciprocal
    // estimate that is at most one low, then a single correcting subtraction.
    logic [31:0] uc_w;
    logic [56:0] uprod_w;
    logic [31:0] ur_w;
    logic        ufix_w;
    logic [11:0] udig_w;
    logic [19:0] urem_w;
    logic [47:0] uq_w;
    always_comb begin
        uc_w    = {r_urem, r_xs[71:60]};
        uprod_w = {25'd0, uc_w} * {32'd0, US_RECIP};
        ur_w    = r_uc - ({20'd0, r_uqe} * {12'd0, US_PER_SEC});
        ufix_w  = ur_w >= {12'd0, US_PER_SEC};
        udig_w  = r_uqe + {11'd0, ufix_w};
        urem_w  = ufix_w ? 20'(ur_w - {12'd0, US_PER_SEC}) : ur_w[19:0];
        uq_w    = {r_uq[35:0], udig_w};
    end

    logic [47:0] scaled_w;
    assign scaled_w = r_sc - 48'(div_r);

    logic [31:0] size_w;
    assign size_w = r_end[31:0] - r_start[31:0];

    // One piece of the looping buffer.
    logic [31:0] p_w;
    logic [31:0] piece_w;
    logic [31:0] left_w;
    logic        lim_w;
    always_comb begin
        p_w     = (r_pos == {1'b0, r_wave}) ? 32'd0 : r_pos[31:0];
        piece_w = ({1'b0, r_rem} + {1'b0, p_w} > {1'b0, r_wave}) ? (r_wave - p_w) : r_rem;
        left_w  = r_rem - piece_w;
        lim_w   = r_n == SEG_W'(MAX_SEGMENTS - 1);
    end

    // Sequencer with the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dgo   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_dgo <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_span  <= s_axis_tdata[71:40];
                        r_frame <= frame_w;
                        r_k     <= k_w;
                        if (r_slen == '0) begin
                            r_ov    <= 1'b1;
                            r_ost   <= ST_NO_AUDIO;
                            r_oaddr <= '0;
                            r_ocnt  <= '0;
                            r_otot  <= '0;
                            r_olast <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_dgo   <= 1'b1;
                            r_dnd   <= DIV_DW'(s_axis_tdata[39:0]);
                            r_dvs   <= r_slen;
                            r_dnb   <= DIV_CW'(40);
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (div_done) begin
                        r_from  <= div_r[39:0];
                        r_t     <= {1'b0, div_r[39:0]};
                        r_phase <= 1'b0;
                        if (r_frame == '0) begin
                            r_start <= '0;
                            r_end   <= '0;
                            r_state <= S_SIZE;
                        end else begin
                            r_state <= S_MUL_LO;
                        end
                    end
                end
                S_MUL_LO: begin
                    r_prod  <= DIV_DW'({26'd0, r_t[20:0]} * {21'd0, r_k});
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    r_xs    <= {5'd0, prod_n};
                    r_urem  <= '0;
                    r_uq    <= '0;
                    r_dig   <= US_TOP_DIGIT;
                    r_state <= S_US_EST;
                end
                S_US_EST: begin
                    r_uc    <= uc_w;
                    r_uqe   <= uprod_w[US_QSH+11:US_QSH];
                    r_state <= S_US_FIX;
                end
                S_US_FIX: begin
                    r_urem <= urem_w;
                    r_uq   <= uq_w;
                    r_xs   <= {r_xs[59:0], 12'd0};
                    r_dig  <= r_dig - 3'd1;
                    if (r_dig == '0) begin
                        r_sc    <= uq_w;
                        r_dgo   <= 1'b1;
                        r_dnd   <= DIV_DW'(uq_w);
                        r_dvs   <= DIV_VW'(r_frame);
                        r_dnb   <= DIV_CW'(48);
                        r_state <= S_DIV_FR;
                    end else begin
                        r_state <= S_US_EST;
                    end
                end
                S_DIV_FR: begin
                    if (div_done) begin
                        if (!r_phase) begin
                            r_start <= scaled_w;
                            r_t     <= {1'b0, r_from} + {9'd0, r_span};
                            r_phase <= 1'b1;
                            r_state <= S_MUL_LO;
                        end else begin
                            r_end   <= scaled_w;
                            r_state <= S_SIZE;
                        end
                    end
                end
                S_SIZE: begin
                    r_size <= size_w;
                    r_rem  <= size_w;
                    if (size_w == '0) begin
                        r_ov    <= 1'b1;
                        r_ost   <= ST_OK;
                        r_oaddr <= {1'b0, r_base};
                        r_ocnt  <= '0;
                        r_otot  <= '0;
                        r_olast <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_wave == '0) begin
                        r_ov    <= 1'b1;
                        r_ost   <= ST_NO_AUDIO;
                        r_oaddr <= '0;
                        r_ocnt  <= '0;
                        r_otot  <= '0;
                        r_olast <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_dgo   <= 1'b1;
                        r_dnd   <= DIV_DW'(r_start);
                        r_dvs   <= DIV_VW'(r_wave);
                        r_dnb   <= DIV_CW'(48);
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if (div_done) begin
                        r_pos   <= {1'b0, div_r[31:0]};
                        r_n     <= '0;
                        r_state <= S_SEG;
                    end
                end
                S_SEG: begin
                    r_ov    <= 1'b1;
                    r_oaddr <= {1'b0, p_w} + {1'b0, r_base};
                    r_ocnt  <= piece_w;
                    r_otot  <= r_size;
                    r_olast <= (left_w == '0) || lim_w;
                    r_ost   <= ((left_w != '0) && lim_w) ? ST_TRUNCATED : ST_OK;
                    r_pos   <= {1'b0, p_w} + {1'b0, piece_w};
                    r_rem   <= left_w;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_ov <= 1'b0;
                        if (r_olast) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_n     <= r_n + SEG_W'(1);
                            r_state <= S_SEG;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {5'd0, r_otot, r_ocnt, r_oaddr, r_ost};
    assign m_axis_tlast  = r_olast;
endmodule
